// ----- rtl/core/dali_mt_pkg.sv -----
// Package for the lighting-bus Manchester transceiver.
// Holds the command codes, phase types, timing constants and the result word type.
// Depends on nothing; imported by dali_manchester_transceiver_top.
`timescale 1ns / 1ps

package dali_mt_pkg;

	localparam logic [3:0] TICKS_PER_BIT  = 4'd8;
	localparam logic [3:0] TICKS_PER_HALF = 4'd4;
	localparam logic [3:0] TX_STOP_TICKS  = 4'd4;
	localparam logic [3:0] RX_STOP_TICKS  = 4'd4;
	localparam logic [3:0] RX_FIRST_TAP   = 4'd3;
	localparam logic [3:0] RX_SECOND_TAP  = 4'd7;
	localparam logic [4:0] TX_FRAME_BITS  = 5'd16;
	localparam logic [3:0] RX_FRAME_BITS  = 4'd8;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_TAKE  = 2'd2,
		FUNC_ACK   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		TXP_IDLE  = 2'd0,
		TXP_START = 2'd1,
		TXP_DATA  = 2'd2,
		TXP_STOP  = 2'd3
	} tx_phase_t;

	typedef enum logic [2:0] {
		RXP_IDLE   = 3'd0,
		RXP_START  = 3'd1,
		RXP_FIRST  = 3'd2,
		RXP_SECOND = 3'd3,
		RXP_STOP   = 3'd4
	} rx_phase_t;

	typedef struct packed {
		logic       bus_level;
		logic       tx_busy;
		logic       tx_done;
		logic       frame_ready;
		logic [7:0] received_byte;
		logic [3:0] received_bits;
		logic       response_ready;
		logic [7:0] response_byte;
	} result_t;

endpackage

// ----- rtl/core/dali_manchester_transceiver_top.sv -----
// Oversampling Manchester transceiver for a two-level lighting bus, single module.
// Depends on dali_mt_pkg for codes, phase types and the result word.
// An accepted word's result is registered, in the skid register if the result register is full.
// Throughput: one input word per cycle unless stalled; both machines update in a single pass.
// A two-entry output stage (result register plus skid register) lets input continue
// while a result waits; input stalls only when both entries are full.
// Reset (arst_n low, asynchronous) returns both state machines to idle and sets drive_q high.
`timescale 1ns / 1ps

module dali_manchester_transceiver_top
	import dali_mt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic       bus_sample,
	input  logic [7:0] tx_address,
	input  logic [7:0] tx_payload,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       bus_level,
	output logic       tx_busy,
	output logic       tx_done,
	output logic       frame_ready,
	output logic [7:0] received_byte,
	output logic [3:0] received_bits,
	output logic       response_ready,
	output logic [7:0] response_byte
);

	tx_phase_t  tx_phase_q, tx_phase_d;
	logic [3:0] tx_tick_q, tx_tick_d;
	logic [4:0] tx_pos_q, tx_pos_d;
	logic [15:0] tx_frame_q, tx_frame_d;
	logic       tx_active_q, tx_active_d;
	logic       tx_success_q, tx_success_d;
	logic       drive_q, drive_d;

	rx_phase_t  rx_phase_q, rx_phase_d;
	logic [3:0] rx_tick_q, rx_tick_d;
	logic [3:0] rx_pos_q, rx_pos_d;
	logic       first_half_q, first_half_d;
	logic [7:0] rx_shift_q, rx_shift_d;
	logic [3:0] rx_total_q, rx_total_d;
	logic       frame_flag_q, frame_flag_d;
	logic [7:0] resp_latch_q, resp_latch_d;
	logic       resp_flag_q, resp_flag_d;

	logic [3:0] taken;
	logic       in_accept;
	logic       out_take;
	func_t      func_in;
	result_t    result;
	result_t    out_q;
	result_t    skid_q;
	logic       out_valid_q;
	logic       skid_valid_q;

	logic [3:0] tx_tick_inc;
	logic [3:0] rx_tick_inc;
	logic [4:0] tx_pos_inc;
	logic [3:0] rx_pos_inc;
	logic       tx_first_half;
	logic       tx_bit;

	assign func_in   = func_t'(func);
	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;

	assign tx_tick_inc   = tx_tick_q + 4'd1;
	assign rx_tick_inc   = rx_tick_q + 4'd1;
	assign tx_pos_inc    = tx_pos_q + 5'd1;
	assign rx_pos_inc    = rx_pos_q + 4'd1;
	assign tx_first_half = (tx_tick_inc <= TICKS_PER_HALF);
	assign tx_bit        = tx_frame_q[~tx_pos_q[3:0]];

	always_comb begin
		tx_phase_d   = tx_phase_q;
		tx_tick_d    = tx_tick_q;
		tx_pos_d     = tx_pos_q;
		tx_frame_d   = tx_frame_q;
		tx_active_d  = tx_active_q;
		tx_success_d = tx_success_q;
		drive_d      = drive_q;
		rx_phase_d   = rx_phase_q;
		rx_tick_d    = rx_tick_q;
		rx_pos_d     = rx_pos_q;
		first_half_d = first_half_q;
		rx_shift_d   = rx_shift_q;
		rx_total_d   = rx_total_q;
		frame_flag_d = frame_flag_q;
		resp_latch_d = resp_latch_q;
		resp_flag_d  = resp_flag_q;
		taken        = 4'd0;

		unique case (func_in)
			FUNC_TICK: begin
				if (tx_active_q) begin
					tx_tick_d = tx_tick_inc;
					unique case (tx_phase_q)
						TXP_START: begin
							drive_d = tx_first_half;
							if (tx_tick_inc >= TICKS_PER_BIT) begin
								tx_phase_d = TXP_DATA;
								tx_tick_d  = 4'd0;
								tx_pos_d   = 5'd0;
							end
						end
						TXP_DATA: begin
							drive_d = (tx_first_half == tx_bit);
							if (tx_tick_inc >= TICKS_PER_BIT) begin
								tx_pos_d  = tx_pos_inc;
								tx_tick_d = 4'd0;
								if (tx_pos_inc >= TX_FRAME_BITS) begin
									tx_phase_d = TXP_STOP;
								end
							end
						end
						TXP_STOP: begin
							drive_d = 1'b1;
							if (tx_tick_inc >= TX_STOP_TICKS) begin
								tx_phase_d   = TXP_IDLE;
								tx_active_d  = 1'b0;
								tx_success_d = 1'b1;
							end
						end
						TXP_IDLE: begin
							tx_active_d = 1'b0;
						end
					endcase
				end

				unique case (rx_phase_q)
					RXP_IDLE: begin
						if (!bus_sample) begin
							rx_phase_d = RXP_START;
							rx_tick_d  = 4'd0;
							rx_pos_d   = 4'd0;
							rx_shift_d = 8'd0;
						end
					end
					RXP_START: begin
						rx_tick_d = rx_tick_inc;
						if (rx_tick_inc >= TICKS_PER_BIT) begin
							rx_phase_d = RXP_FIRST;
							rx_tick_d  = 4'd0;
						end
					end
					RXP_FIRST: begin
						rx_tick_d = rx_tick_inc;
						if (rx_tick_inc == RX_FIRST_TAP) begin
							first_half_d = bus_sample;
						end
						if (rx_tick_inc >= TICKS_PER_HALF) begin
							rx_phase_d = RXP_SECOND;
						end
					end
					RXP_SECOND: begin
						rx_tick_d = rx_tick_inc;
						if (rx_tick_inc == RX_SECOND_TAP) begin
							rx_shift_d = {rx_shift_q[6:0], first_half_q && !bus_sample};
						end
						if (rx_tick_inc >= TICKS_PER_BIT) begin
							rx_tick_d = 4'd0;
							rx_pos_d  = rx_pos_inc;
							if (rx_pos_inc >= RX_FRAME_BITS) begin
								rx_total_d   = RX_FRAME_BITS;
								frame_flag_d = 1'b1;
								resp_latch_d = rx_shift_q;
								resp_flag_d  = 1'b1;
								rx_phase_d   = RXP_STOP;
							end else begin
								rx_phase_d = RXP_FIRST;
							end
						end
					end
					RXP_STOP: begin
						rx_tick_d = rx_tick_inc;
						if (rx_tick_inc >= RX_STOP_TICKS || bus_sample) begin
							rx_phase_d = RXP_IDLE;
							rx_tick_d  = 4'd0;
						end
					end
					default: begin
						rx_phase_d = RXP_IDLE;
					end
				endcase
			end
			FUNC_START: begin
				rx_phase_d   = RXP_IDLE;
				frame_flag_d = 1'b0;
				rx_total_d   = 4'd0;
				tx_frame_d   = {tx_address, tx_payload};
				tx_pos_d     = 5'd0;
				tx_tick_d    = 4'd0;
				tx_phase_d   = TXP_START;
				tx_active_d  = 1'b1;
				tx_success_d = 1'b0;
				resp_flag_d  = 1'b0;
			end
			FUNC_TAKE: begin
				if (frame_flag_q) begin
					taken        = rx_total_q;
					frame_flag_d = 1'b0;
				end
			end
			FUNC_ACK: begin
				resp_flag_d = 1'b0;
			end
		endcase
	end

	always_comb begin
		result.bus_level      = drive_d;
		result.tx_busy        = tx_active_d;
		result.tx_done        = tx_success_d;
		result.frame_ready    = frame_flag_d;
		result.received_byte  = rx_shift_d;
		result.received_bits  = taken;
		result.response_ready = resp_flag_d;
		result.response_byte  = resp_latch_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_phase_q   <= TXP_IDLE;
			tx_tick_q    <= 4'd0;
			tx_pos_q     <= 5'd0;
			tx_frame_q   <= 16'd0;
			tx_active_q  <= 1'b0;
			tx_success_q <= 1'b0;
			drive_q      <= 1'b1;
			rx_phase_q   <= RXP_IDLE;
			rx_tick_q    <= 4'd0;
			rx_pos_q     <= 4'd0;
			first_half_q <= 1'b0;
			rx_shift_q   <= 8'd0;
			rx_total_q   <= 4'd0;
			frame_flag_q <= 1'b0;
			resp_latch_q <= 8'd0;
			resp_flag_q  <= 1'b0;
		end else if (in_accept) begin
			tx_phase_q   <= tx_phase_d;
			tx_tick_q    <= tx_tick_d;
			tx_pos_q     <= tx_pos_d;
			tx_frame_q   <= tx_frame_d;
			tx_active_q  <= tx_active_d;
			tx_success_q <= tx_success_d;
			drive_q      <= drive_d;
			rx_phase_q   <= rx_phase_d;
			rx_tick_q    <= rx_tick_d;
			rx_pos_q     <= rx_pos_d;
			first_half_q <= first_half_d;
			rx_shift_q   <= rx_shift_d;
			rx_total_q   <= rx_total_d;
			frame_flag_q <= frame_flag_d;
			resp_latch_q <= resp_latch_d;
			resp_flag_q  <= resp_flag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_accept) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (in_accept) begin
			if (out_valid_q && !out_take) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign bus_level      = out_q.bus_level;
	assign tx_busy        = out_q.tx_busy;
	assign tx_done        = out_q.tx_done;
	assign frame_ready    = out_q.frame_ready;
	assign received_byte  = out_q.received_byte;
	assign received_bits  = out_q.received_bits;
	assign response_ready = out_q.response_ready;
	assign response_byte  = out_q.response_byte;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while the result register is empty");

	a_busy_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		tx_active_q == (tx_phase_q != TXP_IDLE))
		else $error("transmitter busy flag disagrees with its phase");

	a_frame_total: assert property (@(posedge clk) disable iff (!arst_n)
		frame_flag_q |-> (rx_total_q == RX_FRAME_BITS))
		else $error("frame flagged without a full bit count");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && func_in == FUNC_START) |=> (tx_active_q && !tx_success_q))
		else $error("start word did not arm the transmitter");

	a_take_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && func_in != FUNC_TAKE) |-> (taken == 4'd0))
		else $error("bit count returned on a word other than take");

endmodule

// ----- test/dali_manchester_transceiver_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dali_manchester_transceiver_top: tick, start, take and acknowledge
// words under random idling on both channels, each result word checked against a local predictor.
// Depends on dali_mt_pkg and the top-level RTL.

module dali_manchester_transceiver_top_tb;
	import dali_mt_pkg::*;

	localparam int STIM_WORDS  = 1370;
	localparam int PHASE_WORDS = 150;
	localparam int QUIET_LIMIT = 1000;

	typedef struct {
		func_t      func;
		logic       sample;
		logic [7:0] addr;
		logic [7:0] data;
		bit         drain;
	} bus_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] func = FUNC_TICK;
	logic       bus_sample = 1'b1;
	logic [7:0] tx_address = 8'h00;
	logic [7:0] tx_payload = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       bus_level;
	logic       tx_busy;
	logic       tx_done;
	logic       frame_ready;
	logic [7:0] received_byte;
	logic [3:0] received_bits;
	logic       response_ready;
	logic [7:0] response_byte;

	bus_word_t pending_q[$];
	result_t   expected_q[$];
	int        words_taken = 0;
	int        error_count = 0;
	int        quiet_cycles = 0;
	bit        in_took = 1'b0;

	tx_phase_t  tx_ph = TXP_IDLE;
	logic [3:0] tx_ticks = '0;
	logic [4:0] tx_bit_idx = '0;
	logic [15:0] tx_word = '0;
	logic       tx_on = 1'b0;
	logic       tx_ok = 1'b0;
	logic       line_level = 1'b1;
	rx_phase_t  rx_ph = RXP_IDLE;
	logic [3:0] rx_ticks = '0;
	logic [3:0] rx_bit_idx = '0;
	logic [3:0] rx_count = '0;
	logic       half_sample = 1'b0;
	logic [7:0] rx_byte = '0;
	logic [7:0] resp_byte = '0;
	logic       frame_pending = 1'b0;
	logic       resp_pending = 1'b0;

	dali_manchester_transceiver_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.bus_sample     (bus_sample),
		.tx_address     (tx_address),
		.tx_payload     (tx_payload),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.bus_level      (bus_level),
		.tx_busy        (tx_busy),
		.tx_done        (tx_done),
		.frame_ready    (frame_ready),
		.received_byte  (received_byte),
		.received_bits  (received_bits),
		.response_ready (response_ready),
		.response_byte  (response_byte)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic result_t predict_transceiver(bus_word_t w);
		result_t r;
		logic    bit_val;
		r.received_bits = 4'd0;
		case (w.func)
		FUNC_TICK: begin
			if (tx_on) begin
				tx_ticks = tx_ticks + 4'd1;
				case (tx_ph)
				TXP_START: begin
					line_level = (tx_ticks <= TICKS_PER_HALF);
					if (tx_ticks >= TICKS_PER_BIT) begin
						tx_ph = TXP_DATA;
						tx_ticks = '0;
						tx_bit_idx = '0;
					end
				end
				TXP_DATA: begin
					bit_val = tx_word[4'd15 - tx_bit_idx[3:0]];
					line_level = ((tx_ticks <= TICKS_PER_HALF) == bit_val);
					if (tx_ticks >= TICKS_PER_BIT) begin
						tx_bit_idx = tx_bit_idx + 5'd1;
						tx_ticks = '0;
						if (tx_bit_idx >= TX_FRAME_BITS)
							tx_ph = TXP_STOP;
					end
				end
				TXP_STOP: begin
					line_level = 1'b1;
					if (tx_ticks >= TX_STOP_TICKS) begin
						tx_ph = TXP_IDLE;
						tx_on = 1'b0;
						tx_ok = 1'b1;
					end
				end
				default: begin
					tx_ph = TXP_IDLE;
					tx_on = 1'b0;
				end
				endcase
			end
			case (rx_ph)
			RXP_IDLE: begin
				if (!w.sample) begin
					rx_ph = RXP_START;
					rx_ticks = '0;
					rx_bit_idx = '0;
					rx_byte = '0;
				end
			end
			RXP_START: begin
				rx_ticks = rx_ticks + 4'd1;
				if (rx_ticks >= TICKS_PER_BIT) begin
					rx_ph = RXP_FIRST;
					rx_ticks = '0;
				end
			end
			RXP_FIRST: begin
				rx_ticks = rx_ticks + 4'd1;
				if (rx_ticks == RX_FIRST_TAP)
					half_sample = w.sample;
				if (rx_ticks >= TICKS_PER_HALF)
					rx_ph = RXP_SECOND;
			end
			RXP_SECOND: begin
				rx_ticks = rx_ticks + 4'd1;
				if (rx_ticks == RX_SECOND_TAP)
					rx_byte = {rx_byte[6:0], half_sample & ~w.sample};
				if (rx_ticks >= TICKS_PER_BIT) begin
					rx_ticks = '0;
					rx_bit_idx = rx_bit_idx + 4'd1;
					if (rx_bit_idx >= RX_FRAME_BITS) begin
						rx_count = RX_FRAME_BITS;
						frame_pending = 1'b1;
						resp_byte = rx_byte;
						resp_pending = 1'b1;
						rx_ph = RXP_STOP;
					end else begin
						rx_ph = RXP_FIRST;
					end
				end
			end
			RXP_STOP: begin
				rx_ticks = rx_ticks + 4'd1;
				if (rx_ticks >= RX_STOP_TICKS || w.sample) begin
					rx_ph = RXP_IDLE;
					rx_ticks = '0;
				end
			end
			default: begin
				rx_ph = RXP_IDLE;
			end
			endcase
		end
		FUNC_START: begin
			rx_ph = RXP_IDLE;
			frame_pending = 1'b0;
			rx_count = '0;
			tx_word = {w.addr, w.data};
			tx_bit_idx = '0;
			tx_ticks = '0;
			tx_ph = TXP_START;
			tx_on = 1'b1;
			tx_ok = 1'b0;
			resp_pending = 1'b0;
		end
		FUNC_TAKE: begin
			if (frame_pending) begin
				r.received_bits = rx_count;
				frame_pending = 1'b0;
			end
		end
		default: begin
			resp_pending = 1'b0;
		end
		endcase
		r.bus_level = line_level;
		r.tx_busy = tx_on;
		r.tx_done = tx_ok;
		r.frame_ready = frame_pending;
		r.received_byte = rx_byte;
		r.response_ready = resp_pending;
		r.response_byte = resp_byte;
		return r;
	endfunction

	task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	task automatic push_word(func_t f, logic s, logic [7:0] a, logic [7:0] d, bit drain);
		bus_word_t w;
		w.func = f;
		w.sample = s;
		w.addr = a;
		w.data = d;
		w.drain = drain;
		pending_q.push_back(w);
	endtask

	task automatic push_tick(logic s);
		push_word(FUNC_TICK, s, 8'($urandom), 8'($urandom), 1'b0);
	endtask

	// A backward frame: a low sample wakes the receiver, the rest of the start bit,
	// eight Manchester bits MSB first, then a stop that may hold the bus low for a while.
	task automatic push_backward_frame(bit noisy);
		logic [7:0] value;
		logic       level;
		int         pick;
		pick = $urandom_range(7);
		value = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
		repeat ($urandom_range(3)) push_tick(1'b1);
		for (int i = 0; i < 9; i++)
			push_tick(i >= 4);
		for (int b = 7; b >= 0; b--) begin
			for (int k = 0; k < 8; k++) begin
				level = (k < 4) ? value[b] : ~value[b];
				if (noisy && $urandom_range(11) == 0)
					level = ~level;
				push_tick(level);
			end
			if (noisy && $urandom_range(15) == 0)
				push_word(func_t'($urandom_range(3, 2)), 1'($urandom_range(1)),
					8'($urandom), 8'($urandom), 1'b0);
		end
		repeat ($urandom_range(5)) push_tick($urandom_range(2) == 0);
		repeat ($urandom_range(3, 1)) push_tick(1'b1);
	endtask

	always @(posedge clk) begin
		result_t   want;
		bus_word_t w;
		if (arst_n) begin
			in_took = in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result word, expected none, actual %h", $time,
						{bus_level, tx_busy, tx_done, frame_ready, received_byte,
						received_bits, response_ready, response_byte});
				end else begin
					want = expected_q.pop_front();
					compare_field("bus_level", want.bus_level, bus_level);
					compare_field("tx_busy", want.tx_busy, tx_busy);
					compare_field("tx_done", want.tx_done, tx_done);
					compare_field("frame_ready", want.frame_ready, frame_ready);
					compare_field("received_byte", want.received_byte, received_byte);
					compare_field("received_bits", want.received_bits, received_bits);
					compare_field("response_ready", want.response_ready, response_ready);
					compare_field("response_byte", want.response_byte, response_byte);
				end
			end
			if (in_took) begin
				w.func = func_t'(func);
				w.sample = bus_sample;
				w.addr = tx_address;
				w.data = tx_payload;
				w.drain = 1'b0;
				expected_q.push_back(predict_transceiver(w));
				words_taken++;
			end
			if (in_took || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	always @(negedge clk) begin
		int        mode;
		bus_word_t w;
		mode = (words_taken / PHASE_WORDS) % 4;
		out_stall <= arst_n && ((mode == 2 && $urandom_range(99) < 49) ||
			(mode == 3 && $urandom_range(99) < 16));
		if (arst_n && (!in_valid || in_took)) begin
			if (pending_q.size() == 0 || (pending_q[0].drain && expected_q.size() != 0) ||
				(mode == 1 && $urandom_range(99) < 49) ||
				(mode == 3 && $urandom_range(99) < 16)) begin
				in_valid <= 1'b0;
			end else begin
				w = pending_q.pop_front();
				in_valid <= 1'b1;
				func <= w.func;
				bus_sample <= w.sample;
				tx_address <= w.addr;
				tx_payload <= w.data;
			end
		end
	end

	initial begin
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int  pick;
		int  base;
		bit  drain;
		push_word(FUNC_TAKE, 1'b0, 8'hFF, 8'hFF, 1'b0);
		push_word(FUNC_ACK, 1'b1, 8'h00, 8'h00, 1'b0);
		push_word(FUNC_TICK, 1'b1, 8'hFF, 8'h00, 1'b0);
		push_word(FUNC_TICK, 1'b0, 8'h00, 8'hFF, 1'b0);
		push_word(FUNC_TICK, 1'b0, 8'h00, 8'h00, 1'b0);
		push_word(FUNC_START, 1'b1, 8'hFF, 8'h00, 1'b0);
		repeat (5) push_tick(1'b1);
		push_word(FUNC_START, 1'b0, 8'h00, 8'hFF, 1'b0);
		repeat (6) push_tick(1'b0);
		push_word(FUNC_TAKE, 1'b1, 8'h00, 8'h00, 1'b0);
		push_word(FUNC_ACK, 1'b0, 8'hFF, 8'hFF, 1'b0);
		push_word(FUNC_START, 1'b1, 8'hA5, 8'h5A, 1'b0);
		push_tick(1'b1);
		drain = 1'b1;
		while (pending_q.size() < STIM_WORDS) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				push_word(FUNC_TICK, 1'b1, 8'($urandom), 8'($urandom), drain);
				push_backward_frame(pick >= 30);
			end else if (pick < 75) begin
				if (pick >= 65) begin
					push_word(FUNC_START, 1'($urandom_range(1)), 8'($urandom), 8'($urandom),
						drain);
					repeat ($urandom_range(60, 1)) push_tick(1'($urandom_range(1)));
					drain = 1'b0;
				end
				base = pending_q.size();
				push_word(FUNC_START, 1'($urandom_range(1)), 8'($urandom), 8'($urandom), drain);
				if ($urandom_range(1))
					push_backward_frame(1'b0);
				while (pending_q.size() - base < 150)
					push_tick(1'b1);
			end else begin
				push_word(func_t'($urandom_range(3)), 1'($urandom_range(1)), 8'($urandom),
					8'($urandom), drain);
				repeat ($urandom_range(11)) push_word(func_t'($urandom_range(3)),
					1'($urandom_range(1)), 8'($urandom), 8'($urandom), 1'b0);
			end
			if ($urandom_range(1))
				push_word(FUNC_TAKE, 1'($urandom_range(1)), 8'($urandom), 8'($urandom), 1'b0);
			if ($urandom_range(1))
				push_word(FUNC_ACK, 1'($urandom_range(1)), 8'($urandom), 8'($urandom), 1'b0);
			if ($urandom_range(3) == 0)
				push_word(FUNC_TAKE, 1'($urandom_range(1)), 8'($urandom), 8'($urandom), 1'b0);
			drain = ($urandom_range(5) == 0);
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/dali_mt_pkg.sv
rtl/core/dali_manchester_transceiver_top.sv
test/dali_manchester_transceiver_top_tb.sv
